// ===== design/srt_pkg.sv =====
// Shared types, constants and item codes for the trapezoidal stepper ramp.
// No dependencies; imported by every module of the block.
package srt_pkg;

  // width of the step up-counter; the pull ends when it overflows
  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned LEN_BITS     = 16;
  localparam int unsigned SPEED_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [LEN_BITS-1:0]     len_t;
  typedef logic [SPEED_BITS-1:0]   speed_t;

  // request kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORMAL_LENGTH = 3'd0,
    REG_CLEAR_LENGTH  = 3'd1,
    REG_PULLS_PER_CLR = 3'd2,
    REG_PULL_TARGET   = 3'd3,
    REG_CLEAR_TARGET  = 3'd4,
    REG_RAMP_DIVIDER  = 3'd5,
    REG_START_SPEED   = 3'd6,
    REG_RATIO_3TO1    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    len_t         normal_length;
    len_t         clear_length;
    logic [7:0]   pulls_per_clear;
    speed_t       pull_target_speed;
    speed_t       clear_target_speed;
    logic [7:0]   ramp_divider;
    speed_t       start_speed;
    logic         ratio_three_to_one;
  } cfg_t;

  // ramp profile state touched by ramp ticks
  typedef struct packed {
    logic [7:0] tick_count;
    speed_t     compare_value;
    logic       accelerating;
    logic       decel_begun;
    cnt_t       turn_point;
  } ramp_state_t;

  // values loaded by a start request
  typedef struct packed {
    len_t       length;
    speed_t     target_speed;
    logic [7:0] pulls_done;
    cnt_t       turn_point;
    cnt_t       reload_value;
  } start_load_t;

endpackage

// ===== design/srt_length.sv =====
// Pull length selection and scaling for a start request.
// Depends on srt_pkg.
module srt_length (
  input  srt_pkg::cfg_t        cfg,
  input  logic [7:0]           pulls_done,
  input  srt_pkg::len_t        offset_subtract,
  output srt_pkg::start_load_t load
);
  import srt_pkg::*;

  logic  take_clear;
  len_t  base_len;
  len_t  sub_len;
  len_t  triple_len;
  len_t  final_len;
  cnt_t  half_ext;
  cnt_t  len_ext;

  // clearing pull after every pulls_per_clear normal pulls
  assign take_clear = (cfg.pulls_per_clear != 8'd0) && (pulls_done >= cfg.pulls_per_clear);
  assign base_len   = take_clear ? cfg.clear_length : cfg.normal_length;

  // offset and optional three-quarter scaling, 16-bit wrap
  assign sub_len    = base_len - offset_subtract;
  assign triple_len = sub_len + {sub_len[LEN_BITS-2:0], 1'b0};
  assign final_len  = cfg.ratio_three_to_one ? {2'b00, triple_len[LEN_BITS-1:2]} : sub_len;

  assign half_ext = cnt_t'({1'b0, final_len[LEN_BITS-1:1]});
  assign len_ext  = cnt_t'(final_len);

  // counter preload and midpoint turn
  always_comb begin
    load.length       = final_len;
    load.target_speed = take_clear ? cfg.clear_target_speed : cfg.pull_target_speed;
    if (take_clear) begin
      load.pulls_done = 8'd0;
    end else if (cfg.pulls_per_clear != 8'd0) begin
      load.pulls_done = pulls_done + 8'd1;
    end else begin
      load.pulls_done = 8'd0;
    end
    load.turn_point   = cnt_t'(0) - half_ext;
    load.reload_value = cnt_t'(0) - len_ext;
  end

endmodule

// ===== design/srt_ramp.sv =====
// Acceleration and deceleration step of the compare value on a ramp tick.
// Depends on srt_pkg.
module srt_ramp (
  input  srt_pkg::cfg_t        cfg,
  input  srt_pkg::cnt_t        step_counter,
  input  srt_pkg::cnt_t        reload_value,
  input  srt_pkg::speed_t      target_speed,
  input  srt_pkg::ramp_state_t cur,
  output srt_pkg::ramp_state_t nxt
);
  import srt_pkg::*;

  logic [7:0] tc_dec;

  // mirror the tick phase on entry to deceleration
  assign tc_dec = cur.decel_begun ? cur.tick_count : (cfg.ramp_divider - cur.tick_count);

  always_comb begin
    nxt = cur;
    if (step_counter > cur.turn_point) begin
      // past the turn: slow down, guarded by the start speed
      nxt.decel_begun = 1'b1;
      nxt.tick_count  = tc_dec;
      if (cur.compare_value <= cfg.start_speed) begin
        if (tc_dec >= cfg.ramp_divider) begin
          nxt.tick_count = 8'd0;
          if (cur.compare_value != SPEED_MAX) begin
            nxt.compare_value = cur.compare_value + speed_t'(1);
          end
        end else begin
          nxt.tick_count = tc_dec + 8'd1;
        end
      end
    end else if (cur.accelerating) begin
      // speeding up toward the target
      if (cur.compare_value > target_speed) begin
        if (cur.tick_count >= cfg.ramp_divider) begin
          nxt.tick_count    = 8'd0;
          nxt.compare_value = cur.compare_value - speed_t'(1);
        end else begin
          nxt.tick_count = cur.tick_count + 8'd1;
        end
      end else begin
        // target reached early: turn at the mirrored point
        nxt.turn_point   = reload_value - step_counter;
        nxt.accelerating = 1'b0;
      end
    end
  end

endmodule

// ===== design/stepper_trapezoid_ramp.sv =====
// Trapezoidal speed ramp for a foil-pull stepper: profile state, config and result register.
// Depends on srt_pkg, srt_length and srt_ramp.
//
// Each request (start pull, motor step pulse or ramp tick) updates the profile state
// at the edge that accepts it, and its result lands in a single output register.
// A new request is taken every cycle while the result is either empty or being
// taken at the same edge, so the block sustains one request per clock as long as
// out_ready is not held low; each state update feeds that output register.
// A start while a pull runs, and steps or ticks while idle, only report current state.
// Configuration writes take effect at once and should be made while the block is idle.
module stepper_trapezoid_ramp (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic [15:0]                          offset_subtract,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           pwm_compare,
  output logic                                 running,
  output logic                                 done_res,
  output logic [15:0]                          loaded_length,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [srt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [srt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import srt_pkg::*;

  cfg_t        cfg;
  cnt_t        step_counter, step_counter_next;
  cnt_t        reload_value, reload_value_next;
  speed_t      target_speed, target_speed_next;
  logic [7:0]  pulls_done, pulls_done_next;
  logic        busy, busy_next;
  len_t        loaded_len, loaded_len_next;
  ramp_state_t ramp, ramp_next;
  ramp_state_t ramp_tick;
  start_load_t load;
  logic        done_next;
  cnt_t        step_inc;
  logic        in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_length      <= '0;
      cfg.clear_length       <= '0;
      cfg.pulls_per_clear    <= '0;
      cfg.pull_target_speed  <= SPEED_MAX;
      cfg.clear_target_speed <= SPEED_MAX;
      cfg.ramp_divider       <= 8'd60;
      cfg.start_speed        <= SPEED_MAX;
      cfg.ratio_three_to_one <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NORMAL_LENGTH: cfg.normal_length      <= cfg_data;
        REG_CLEAR_LENGTH:  cfg.clear_length       <= cfg_data;
        REG_PULLS_PER_CLR: cfg.pulls_per_clear    <= cfg_data[7:0];
        REG_PULL_TARGET:   cfg.pull_target_speed  <= cfg_data[7:0];
        REG_CLEAR_TARGET:  cfg.clear_target_speed <= cfg_data[7:0];
        REG_RAMP_DIVIDER:  cfg.ramp_divider       <= cfg_data[7:0];
        REG_START_SPEED:   cfg.start_speed        <= cfg_data[7:0];
        REG_RATIO_3TO1:    cfg.ratio_three_to_one <= cfg_data[0];
        default: ;
      endcase
    end
  end

  srt_length u_length (
    .cfg             (cfg),
    .pulls_done      (pulls_done),
    .offset_subtract (offset_subtract),
    .load            (load)
  );

  srt_ramp u_ramp (
    .cfg          (cfg),
    .step_counter (step_counter),
    .reload_value (reload_value),
    .target_speed (target_speed),
    .cur          (ramp),
    .nxt          (ramp_tick)
  );

  assign step_inc = step_counter + cnt_t'(1);

  // next state for the request at the input
  always_comb begin
    step_counter_next = step_counter;
    reload_value_next = reload_value;
    target_speed_next = target_speed;
    pulls_done_next   = pulls_done;
    busy_next         = busy;
    loaded_len_next   = loaded_len;
    ramp_next         = ramp;
    done_next         = 1'b0;
    unique case (kind_t'(kind))
      KIND_START: begin
        if (!busy) begin
          step_counter_next       = load.reload_value;
          reload_value_next       = load.reload_value;
          target_speed_next       = load.target_speed;
          pulls_done_next         = load.pulls_done;
          loaded_len_next         = load.length;
          busy_next               = 1'b1;
          ramp_next.tick_count    = 8'd0;
          ramp_next.compare_value = cfg.start_speed;
          ramp_next.accelerating  = 1'b1;
          ramp_next.decel_begun   = 1'b0;
          ramp_next.turn_point    = load.turn_point;
        end
      end
      KIND_STEP: begin
        if (busy) begin
          step_counter_next = step_inc;
          if (step_inc == cnt_t'(0)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (busy) begin
          ramp_next = ramp_tick;
        end
      end
      default: ;
    endcase
  end

  // profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter       <= '0;
      reload_value       <= '0;
      target_speed       <= '0;
      pulls_done         <= '0;
      busy               <= 1'b0;
      loaded_len         <= '0;
      ramp.tick_count    <= '0;
      ramp.compare_value <= SPEED_MAX;
      ramp.accelerating  <= 1'b1;
      ramp.decel_begun   <= 1'b0;
      ramp.turn_point    <= '0;
    end else if (in_fire) begin
      step_counter <= step_counter_next;
      reload_value <= reload_value_next;
      target_speed <= target_speed_next;
      pulls_done   <= pulls_done_next;
      busy         <= busy_next;
      loaded_len   <= loaded_len_next;
      ramp         <= ramp_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pwm_compare   <= ramp_next.compare_value;
      running       <= busy_next;
      done_res      <= done_next;
      loaded_length <= loaded_len_next;
    end
  end

  // a completing step pulse never reports a running pull
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !running)
    else $error("done result with pull still running");

  // an accepted start from idle always begins a fresh acceleration
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == KIND_START && !busy
      |=> busy && ramp.accelerating && !ramp.decel_begun && ramp.tick_count == 8'd0)
    else $error("start did not load a fresh ramp");

  // the counter only moves while a pull runs
  a_counter_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !(in_fire && kind == KIND_START) |=> $stable(step_counter))
    else $error("step counter moved while idle");

  // the result register mirrors the busy flag after each request
  a_running_tracks: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> running == busy)
    else $error("running result disagrees with busy state");

endmodule
